FILE: rtl/b26_pkg.sv
// ----------------------------------------------------------------------------
// b26_pkg: shared types and constants of the base-26 / decimal converter
// Widths, character codes, radix values and divider sizing.
// ----------------------------------------------------------------------------
package b26_pkg;

   // accumulator width and output length limit
   localparam int VALUE_BITS    = 32;
   localparam int MAX_OUT_CHARS = 10;

   // product of the accumulator and a radix, plus one digit
   localparam int PROD_W = VALUE_BITS + 5;

   // output character counter and buffer index
   localparam int CNT_W = $clog2(MAX_OUT_CHARS + 1);
   localparam int IDX_W = $clog2(MAX_OUT_CHARS);

   // divider: quotient bits retired per cycle, padded dividend width
   localparam int DIVISOR_W  = 5;
   localparam int DIV_STEP   = 4;
   localparam int QUO_BITS   = ((VALUE_BITS + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
   localparam int DIV_CYCLES = QUO_BITS / DIV_STEP;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

   localparam logic [DIVISOR_W-1:0] RADIX_LETTER  = DIVISOR_W'(26);
   localparam logic [DIVISOR_W-1:0] RADIX_DECIMAL = DIVISOR_W'(10);

   // ASCII codes
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_A   = 8'h61;
   localparam logic [7:0] CH_Z   = 8'h7A;
   localparam logic [7:0] CH_0   = 8'h30;
   localparam logic [7:0] CH_9   = 8'h39;

   typedef enum logic [1:0] {
      WC_NONE   = 2'd0,
      WC_LETTER = 2'd1,
      WC_DIGIT  = 2'd2
   } word_class_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_MIXED    = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

endpackage

FILE: rtl/b26_req_if.sv
// ----------------------------------------------------------------------------
// b26_req_if: character input channel
// Valid/ready channel carrying one character and its end-of-word flag.
// ----------------------------------------------------------------------------
interface b26_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       word_end;

   modport source (output valid, output char_in, output word_end, input ready);
   modport sink   (input valid, input char_in, input word_end, output ready);
endinterface

FILE: rtl/b26_rsp_if.sv
// ----------------------------------------------------------------------------
// b26_rsp_if: converted character output channel
// Valid/ready channel carrying one result character with its flags.
// ----------------------------------------------------------------------------
interface b26_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       out_last;
   logic [1:0] status;
   logic       empty_word;

   modport source (output valid, output out_char, output out_last, output status,
                   output empty_word, input ready);
   modport sink   (input valid, input out_char, input out_last, input status,
                   input empty_word, output ready);
endinterface

FILE: rtl/b26_divider.sv
// ----------------------------------------------------------------------------
// b26_divider: iterative divider by a small radix
// Restoring division, DIV_STEP quotient bits per cycle; done pulses once.
// ----------------------------------------------------------------------------
module b26_divider
   import b26_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [VALUE_BITS-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [QUO_BITS-1:0]  quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;

   // DIV_STEP chained compare-subtract steps on the narrow remainder
   always_comb begin
      logic [DIVISOR_W:0]   trial;
      logic [DIVISOR_W-1:0] rem_w;
      logic [QUO_BITS-1:0]  quo_w;
      rem_w = rem_ff;
      quo_w = quo_ff;
      for (int i = 0; i < DIV_STEP; i++) begin
         trial = {rem_w, quo_w[QUO_BITS-1]};
         quo_w = {quo_w[QUO_BITS-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            trial    = trial - {1'b0, divisor};
            quo_w[0] = 1'b1;
         end
         rem_w = trial[DIVISOR_W-1:0];
      end

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = QUO_BITS'(dividend);
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = quo_w;
         rem_in = rem_w;
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff[VALUE_BITS-1:0];
   assign remainder = rem_ff;

endmodule

FILE: rtl/base26_letters_decimal_converter.sv
// ----------------------------------------------------------------------------
// base26_letters_decimal_converter: column-name <-> decimal converter
// Reads a word of lowercase letters as bijective base 26 and emits it in
// decimal, or reads leading decimal digits and emits them as letters.
// ----------------------------------------------------------------------------
//
//   channel | direction | word contents                          | accepted when
//   --------+-----------+----------------------------------------+---------------
//   req     | in        | char_in[7:0], word_end                 | valid & ready
//   rsp     | out       | out_char[7:0], out_last, status[1:0],  | valid & ready
//           |           | empty_word                             |
//
// Flow: one character word is taken per cycle while idle. On word_end the
//   sequencer produces each output character by check, the shared
//   4-bit-per-cycle divider, which sets the word-end latency, and store,
//   then streams the buffered characters one per cycle unless rsp is held;
//   error and empty results go from check to a single result word.
// Reset: synchronous, active high; clears the sequencer, word state and the
//   output valid. The character buffer holds no reset value.
// Stalls: req.ready is high only while idle; a held rsp word blocks the
//   streaming of the next character, never the idle acceptance of input.
// ----------------------------------------------------------------------------
module base26_letters_decimal_converter
   import b26_pkg::*;
(
   input logic       clock,
   input logic       reset,
   b26_req_if.sink   req,
   b26_rsp_if.source rsp
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_CHECK  = 6'b000010,
      S_DIV    = 6'b000100,
      S_STORE  = 6'b001000,
      S_EMIT   = 6'b010000,
      S_SINGLE = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   word_class_type        class_ff, class_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  stop_ff, stop_in;
   status_type            err_ff, err_in;
   logic [CNT_W-1:0]      n_ff, n_in;

   // characters, least significant first
   logic [7:0] buf_ff [MAX_OUT_CHARS];

   // output register
   logic       rsp_valid_ff;
   logic [7:0] rsp_char_ff;
   logic       rsp_last_ff;
   status_type rsp_status_ff;
   logic       rsp_empty_ff;

   logic       out_free;
   logic       out_load;
   logic [7:0] load_char;
   logic       load_last;
   status_type load_status;
   logic       load_empty;

   // per-character update
   logic                  is_letter, is_num;
   logic [DIVISOR_W-1:0]  radix;
   logic [DIVISOR_W-1:0]  digit;
   logic [PROD_W-1:0]     prod;
   logic                  prod_ovf;
   word_class_type        upd_class;
   logic [VALUE_BITS-1:0] upd_acc;
   logic                  upd_stop;
   status_type            upd_err;

   // shared divider
   logic                  div_start;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quo;
   logic [DIVISOR_W-1:0]  div_rem;
   logic [DIVISOR_W-1:0]  div_divisor;

   // digit store
   logic                  buf_we;
   logic [7:0]            store_char;
   logic [VALUE_BITS-1:0] next_v;
   logic [CNT_W-1:0]      rd_full;
   logic [IDX_W-1:0]      rd_idx;

   assign out_free = !rsp_valid_ff || rsp.ready;

   // ---- accumulate one character -------------------------------------------
   always_comb begin
      is_letter = req.char_in inside {[CH_A:CH_Z]};
      is_num    = req.char_in inside {[CH_0:CH_9]};
      radix     = is_letter ? RADIX_LETTER : RADIX_DECIMAL;
      digit     = is_letter ? DIVISOR_W'(req.char_in - CH_A + 8'd1)
                            : DIVISOR_W'(req.char_in - CH_0);
      prod      = PROD_W'(acc_ff) * PROD_W'(radix) + PROD_W'(digit);
      // past the accumulator width: flag it, keep the old value
      prod_ovf  = |prod[PROD_W-1:VALUE_BITS];

      upd_class = class_ff;
      upd_acc   = acc_ff;
      upd_stop  = stop_ff;
      upd_err   = err_ff;
      if (req.char_in != CH_NUL) begin
         if (is_letter) begin
            if (class_ff == WC_DIGIT) begin
               upd_err = ST_MIXED;
            end else begin
               upd_class = WC_LETTER;
               if (err_ff == ST_OK) begin
                  if (prod_ovf) upd_err = ST_OVERFLOW;
                  else          upd_acc = prod[VALUE_BITS-1:0];
               end
            end
         end else begin
            if (class_ff == WC_LETTER) begin
               upd_err = ST_MIXED;
            end else begin
               upd_class = WC_DIGIT;
               if (err_ff == ST_OK && !stop_ff) begin
                  if (is_num) begin
                     if (prod_ovf) upd_err = ST_OVERFLOW;
                     else          upd_acc = prod[VALUE_BITS-1:0];
                  end else begin
                     // first non-digit ends the value
                     upd_stop = 1'b1;
                  end
               end
            end
         end
      end
   end

   // ---- shared divider: radix 26 toward letters, 10 toward decimal --------
   assign div_divisor = (class_ff == WC_DIGIT) ? RADIX_LETTER : RADIX_DECIMAL;

   b26_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (acc_ff),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // ---- map remainder to a character --------------------------------------
   always_comb begin
      if (class_ff == WC_DIGIT) begin
         // bijective: a zero remainder is 'z' and borrows from the quotient
         if (div_rem == '0) begin
            store_char = CH_Z;
            next_v     = div_quo - VALUE_BITS'(1);
         end else begin
            store_char = CH_A - 8'd1 + 8'(div_rem);
            next_v     = div_quo;
         end
      end else begin
         store_char = CH_0 + 8'(div_rem);
         next_v     = div_quo;
      end
   end

   assign rd_full = n_ff - CNT_W'(1);
   assign rd_idx  = rd_full[IDX_W-1:0];

   // ---- sequencer ---------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      class_in    = class_ff;
      acc_in      = acc_ff;
      stop_in     = stop_ff;
      err_in      = err_ff;
      n_in        = n_ff;
      div_start   = 1'b0;
      buf_we      = 1'b0;
      out_load    = 1'b0;
      load_char   = CH_NUL;
      load_last   = 1'b0;
      load_status = ST_OK;
      load_empty  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               class_in = upd_class;
               acc_in   = upd_acc;
               stop_in  = upd_stop;
               err_in   = upd_err;
               if (req.word_end) begin
                  n_in     = '0;
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (err_ff != ST_OK) begin
               state_in = S_SINGLE;
            end else if (n_ff == '0 && class_ff == WC_DIGIT && acc_ff == '0) begin
               // zero value toward letters: empty marker
               state_in = S_SINGLE;
            end else if (n_ff == CNT_W'(MAX_OUT_CHARS)) begin
               err_in   = ST_OVERFLOW;
               state_in = S_SINGLE;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) state_in = S_STORE;
         end
         S_STORE: begin
            buf_we = 1'b1;
            n_in   = n_ff + CNT_W'(1);
            acc_in = next_v;
            if (next_v == '0) begin
               class_in = WC_NONE;
               stop_in  = 1'b0;
               err_in   = ST_OK;
               state_in = S_EMIT;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_EMIT: begin
            // most significant character was stored last
            if (out_free) begin
               out_load  = 1'b1;
               load_char = buf_ff[rd_idx];
               load_last = (n_ff == CNT_W'(1));
               n_in      = rd_full;
               if (n_ff == CNT_W'(1)) state_in = S_IDLE;
            end
         end
         S_SINGLE: begin
            if (out_free) begin
               out_load    = 1'b1;
               load_last   = 1'b1;
               load_status = err_ff;
               load_empty  = (err_ff == ST_OK);
               class_in    = WC_NONE;
               acc_in      = '0;
               stop_in     = 1'b0;
               err_in      = ST_OK;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         class_ff     <= WC_NONE;
         acc_ff       <= '0;
         stop_ff      <= 1'b0;
         err_ff       <= ST_OK;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         class_ff <= class_in;
         acc_ff   <= acc_in;
         stop_ff  <= stop_in;
         err_ff   <= err_in;
         n_ff     <= n_in;
         if (out_load)       rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_char_ff   <= load_char;
         rsp_last_ff   <= load_last;
         rsp_status_ff <= load_status;
         rsp_empty_ff  <= load_empty;
      end
      if (buf_we) buf_ff[n_ff[IDX_W-1:0]] <= store_char;
   end

   assign req.ready      = (state_ff == S_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_char   = rsp_char_ff;
   assign rsp.out_last   = rsp_last_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.empty_word = rsp_empty_ff;

   // ---- checks ------------------------------------------------------------
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide state");

   a_store_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_STORE |-> n_ff < CNT_W'(MAX_OUT_CHARS))
      else $error("character buffer overrun");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> n_ff != '0)
      else $error("streaming with an empty buffer");

   a_end_starts: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && req.word_end |=> state_ff == S_CHECK)
      else $error("word end did not start conversion");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> !rsp_valid_ff || rsp.ready)
      else $error("output word overwritten while held");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the base-26 / decimal column-name converter
// Feeds words of characters through the req channel in random bursts. A
// built-in predictor works out the converted characters of every word, and
// each rsp word is checked field by field against the oldest owed result.
// The receiver stalls on its own pattern, with two long hold-offs.
// ----------------------------------------------------------------------------
module tb
   import b26_pkg::*;
();

   // one character offered on the req channel; hold_back asks the sender to
   // wait until every owed result has come before offering it
   typedef struct {
      logic [7:0] ch;
      logic       fin;
      logic       hold_back;
   } char_item_type;

   // one converted character as seen on the rsp channel
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      status_type st;
      logic       empty;
   } out_char_type;

   // receiver stall styles
   typedef enum logic [1:0] {
      RX_OPEN    = 2'd0,
      RX_COIN    = 2'd1,
      RX_SPARSE  = 2'd2,
      RX_CADENCE = 2'd3
   } rx_style_type;

   localparam logic [63:0] VALUE_MAX  = {64{1'b1}} >> (64 - VALUE_BITS);
   localparam int          RAND_CHARS = 470;
   localparam int          LONG_HOLD  = 400;
   localparam int          SETTLE     = 200;

   logic clock;
   logic reset;

   b26_req_if req_bus();
   b26_rsp_if rsp_bus();

   base26_letters_decimal_converter dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Converter state as the predictor keeps it
   // ------------------------------------------------------------------------
   word_class_type word_kind;
   logic [63:0]    word_value;
   logic           digits_done;
   status_type     word_err;

   char_item_type char_stream[$];   // characters still to be offered
   out_char_type  owed_chars[$];    // converted characters not yet seen

   int unsigned taken_cnt;       // req words accepted, counted at posedge
   int unsigned issued_cnt;      // req words put on the bus by the sender
   int unsigned errors;
   logic        hold_next;

   // Fold one more digit into the word value; refuse to wrap past the limit.
   task automatic add_digit(input logic [63:0] radix, input logic [63:0] d);
      if (word_value > (VALUE_MAX - d) / radix) begin
         word_err = ST_OVERFLOW;
      end else begin
         word_value = word_value * radix + d;
      end
   endtask

   // Advance the predicted word by one character; on the word end, queue
   // the characters the converter owes and clear the word.
   task automatic convert_char(input logic [7:0] c, input logic fin);
      logic [7:0]  rev[$];
      logic [63:0] v;
      logic [63:0] r;
      logic        zero_out;
      zero_out = 1'b0;
      // NUL adds nothing, but its end flag still closes the word
      if (c != CH_NUL) begin
         if (c >= CH_A && c <= CH_Z) begin
            if (word_kind == WC_DIGIT) begin
               word_err = ST_MIXED;
            end else begin
               word_kind = WC_LETTER;
               if (word_err == ST_OK) add_digit(64'd26, 64'(c - CH_A + 8'd1));
            end
         end else begin
            if (word_kind == WC_LETTER) begin
               word_err = ST_MIXED;
            end else begin
               word_kind = WC_DIGIT;
               if (word_err == ST_OK && !digits_done) begin
                  if (c >= CH_0 && c <= CH_9) add_digit(64'd10, 64'(c - CH_0));
                  else digits_done = 1'b1;
               end
            end
         end
      end
      if (!fin) return;

      v = word_value;
      if (word_err == ST_OK) begin
         if (word_kind == WC_DIGIT) begin
            // decimal in, bijective base-26 letters out
            zero_out = (v == 64'd0);
            while (v != 64'd0) begin
               r = v % 64'd26;
               if (rev.size() >= MAX_OUT_CHARS) begin
                  word_err = ST_OVERFLOW;
                  break;
               end
               if (r == 64'd0) begin
                  // remainder zero: emit 'z' and borrow from the quotient
                  rev.push_back(CH_Z);
                  v = v / 64'd26 - 64'd1;
               end else begin
                  rev.push_back(CH_A + 8'(r) - 8'd1);
                  v = v / 64'd26;
               end
            end
         end else begin
            // letters (or an empty word) in, decimal digits out
            do begin
               if (rev.size() >= MAX_OUT_CHARS) begin
                  word_err = ST_OVERFLOW;
                  break;
               end
               rev.push_back(CH_0 + 8'(v % 64'd10));
               v = v / 64'd10;
            end while (v != 64'd0);
         end
      end

      if (word_err != ST_OK) begin
         owed_chars.push_back('{CH_NUL, 1'b1, word_err, 1'b0});
      end else if (zero_out) begin
         owed_chars.push_back('{CH_NUL, 1'b1, ST_OK, 1'b1});
      end else begin
         for (int k = rev.size() - 1; k >= 0; k--)
            owed_chars.push_back('{rev[k], k == 0, ST_OK, 1'b0});
      end
      word_kind   = WC_NONE;
      word_value  = 64'd0;
      digits_done = 1'b0;
      word_err    = ST_OK;
   endtask

   // ------------------------------------------------------------------------
   // Stimulus building
   // ------------------------------------------------------------------------
   task automatic push_char(input logic [7:0] c, input logic fin);
      char_stream.push_back('{c, fin, hold_next});
      hold_next = 1'b0;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
   endtask

   // Any byte outside 'a'..'z' and not NUL.
   function automatic logic [7:0] junk_char();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255)); while (c >= CH_A && c <= CH_Z);
      return c;
   endfunction

   // One random word: mostly well-formed letter or digit words, the rest
   // mixed words, raw noise and empty words.
   task automatic push_random_word();
      logic [7:0] w[$];
      int         kind;
      int         len;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
         len = $urandom_range(1, 7);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 11) == 0) w.push_back(CH_NUL);
            w.push_back(CH_A + 8'($urandom_range(0, 25)));
         end
         if ($urandom_range(0, 7) == 0) w.push_back(CH_NUL);
      end else if (kind < 75) begin
         len = $urandom_range(1, 11);
         for (int i = 0; i < len; i++) w.push_back(CH_0 + 8'($urandom_range(0, 9)));
         if ($urandom_range(0, 2) == 0) begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 1) == 0) w.push_back(junk_char());
               else w.push_back(CH_0 + 8'($urandom_range(0, 9)));
            end
         end
      end else if (kind < 85) begin
         len = $urandom_range(2, 6);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 1) == 0) w.push_back(CH_A + 8'($urandom_range(0, 25)));
            else w.push_back(CH_0 + 8'($urandom_range(0, 9)));
         end
      end else if (kind < 95) begin
         len = $urandom_range(1, 4);
         for (int i = 0; i < len; i++) w.push_back(8'($urandom_range(0, 255)));
      end else begin
         if ($urandom_range(0, 1) == 0) w.push_back(CH_NUL);
         else w.push_back(8'($urandom_range(0, 255)));
      end
      foreach (w[i]) push_char(w[i], i == w.size() - 1);
   endtask

   // ------------------------------------------------------------------------
   // Sender: offer characters at the falling edge, in bursts with gaps
   // ------------------------------------------------------------------------
   char_item_type next_char;
   int            burst_left;
   int            gap_left;

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (taken_cnt == issued_cnt) begin
         // the previous word is gone (or none was offered): pick what comes next
         if (gap_left != 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (char_stream.size() == 0 ||
                      (char_stream[0].hold_back && owed_chars.size() != 0)) begin
            // idle, or drain every owed result before this character
            req_bus.valid <= 1'b0;
         end else begin
            next_char = char_stream.pop_front();
            req_bus.valid    <= 1'b1;
            req_bus.char_in  <= next_char.ch;
            req_bus.word_end <= next_char.fin;
            issued_cnt++;
            if (burst_left <= 1) begin
               // end of burst: draw the next burst and the pause before it
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: ready follows a changing stall style, with long hold-offs
   // ------------------------------------------------------------------------
   rx_style_type rx_style;
   int unsigned  rx_cycle;
   int unsigned  hold_left;
   int unsigned  holds_done;
   logic         rx_ready;

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rx_cycle++;
         if (rx_cycle % 64 == 0) rx_style = rx_style_type'($urandom_range(0, 3));
         // hold off for a long stretch twice, while the sender keeps going,
         // so that the converter backs up and drops req ready
         if (hold_left == 0 && holds_done < 2 && taken_cnt >= 150 + 200 * holds_done) begin
            hold_left = LONG_HOLD;
            holds_done++;
         end
         if (hold_left != 0) begin
            hold_left--;
            rx_ready = 1'b0;
         end else begin
            case (rx_style)
               RX_OPEN:    rx_ready = 1'b1;
               RX_COIN:    rx_ready = 1'($urandom_range(0, 1));
               RX_SPARSE:  rx_ready = ($urandom_range(0, 3) == 0);
               default:    rx_ready = (rx_cycle % 5 != 0);
            endcase
         end
         rsp_bus.ready <= rx_ready;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: predict on every accepted character, check every result word
   // ------------------------------------------------------------------------
   out_char_type got;
   out_char_type want;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            convert_char(req_bus.char_in, req_bus.word_end);
            taken_cnt++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.out_char, rsp_bus.out_last, status_type'(rsp_bus.status),
                    rsp_bus.empty_word};
            if (owed_chars.size() == 0) begin
               errors++;
               $display("%0t: result with none owed: char=%h last=%b status=%0d empty=%b",
                        $time, got.ch, got.last, got.st, got.empty);
            end else begin
               want = owed_chars.pop_front();
               if (got !== want) begin
                  errors++;
                  $display("%0t: mismatch, expected char=%h last=%b status=%0d empty=%b, %s",
                           $time, want.ch, want.last, want.st, want.empty,
                           $sformatf("actual char=%h last=%b status=%0d empty=%b",
                                     got.ch, got.last, got.st, got.empty));
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequence: build the stimulus, reset, run, drain and judge
   // ------------------------------------------------------------------------
   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.char_in  = CH_NUL;
      req_bus.word_end = 1'b0;
      rsp_bus.ready    = 1'b0;
      word_kind        = WC_NONE;
      word_value       = 64'd0;
      digits_done      = 1'b0;
      word_err         = ST_OK;
      taken_cnt        = 0;
      issued_cnt       = 0;
      errors           = 0;
      hold_next        = 1'b0;
      burst_left       = 1;
      gap_left         = 0;
      rx_style         = RX_OPEN;
      rx_cycle         = 0;
      hold_left        = 0;
      holds_done       = 0;

      // directed words
      push_char(CH_NUL, 1'b1);      // empty word: emits '0'
      push_text("a");
      push_text("z");
      push_text("0");               // zero value: empty marker
      push_text("27");              // two-letter result: "aa"
      push_text("4294967295");      // largest value that fits
      push_text("-5");              // no sign handling: value zero
      push_text("12x");             // reading stops at the first non-digit
      push_text("a1");              // mixed classes
      push_text("zzzzzzz");         // letter value overflow
      push_char(8'hFF, 1'b1);       // top byte: digit class, value zero
      push_char(CH_A + 8'd1, 1'b0); // NUL inside a word and NUL closing it
      push_char(CH_NUL, 1'b0);
      push_char(CH_A + 8'd2, 1'b0);
      push_char(CH_NUL, 1'b1);

      // let the directed part drain completely before the random part
      hold_next = 1'b1;
      while (char_stream.size() < RAND_CHARS) begin
         if ($urandom_range(0, 59) == 0) hold_next = 1'b1;
         push_random_word();
      end

      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (char_stream.size() != 0 || taken_cnt != issued_cnt) @(posedge clock);
      while (owed_chars.size() != 0) @(posedge clock);
      // catch anything extra the converter might still send
      repeat (SETTLE) @(posedge clock);

      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
